/* hw/rtl/clpf_pkg.sv */
// package for the command line length payload framer
// holds result kinds, character constants and the result struct
// no dependencies
package clpf_pkg;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_DONE    = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] TAG_S      = 8'h53;
    localparam logic [7:0] TAG_O      = 8'h4F;
    localparam logic [7:0] TAG_W      = 8'h57;

    localparam logic [9:0] LEN_SAT    = 10'd1023;
    localparam logic [1:0] COMMAS_ALL = 2'd3;
    localparam logic [1:0] COMMAS_LEN = 2'd2;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [9:0] index;
        logic       is_data_command;
        logic [9:0] payload_length;
    } result_t;

endpackage

/* hw/rtl/clpf_core.sv */
// framer state registers and per-beat next-state and result logic
// depends on clpf_pkg
module clpf_core #(
    parameter int HEADER_MAX    = 256,
    parameter int LENGTH_DIGITS = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          in_byte,
    output clpf_pkg::result_t   res
);

    localparam int HPW = $clog2(HEADER_MAX + 1);
    localparam int DSW = $clog2(LENGTH_DIGITS + 1);
    localparam logic [HPW-1:0] HDR_LIMIT = HPW'(HEADER_MAX);
    localparam logic [DSW-1:0] DIG_LIMIT = DSW'(LENGTH_DIGITS);
    localparam logic [HPW-1:0] TAG_LEN   = HPW'(3);
    localparam logic [HPW-1:0] TAG_LAST  = HPW'(2);

    logic [HPW-1:0] header_position_reg, header_position_next;
    logic           tag_match_reg, tag_match_next;
    logic           data_command_reg, data_command_next;
    logic [1:0]     comma_count_reg, comma_count_next;
    logic [DSW-1:0] length_digits_seen_reg, length_digits_seen_next;
    logic [9:0]     length_value_reg, length_value_next;
    logic           length_stopped_reg, length_stopped_next;
    logic           in_payload_reg, in_payload_next;
    logic [9:0]     payload_count_reg, payload_count_next;

    logic [HPW+9:0] hp_wide;
    logic [9:0]     hp_index;
    logic [7:0]     tag_char;
    logic           is_digit;
    logic [13:0]    length_acc;
    logic [7:0]     digit_off;
    logic           clear_state;

    assign hp_wide   = {10'b0, header_position_reg};
    assign hp_index  = hp_wide[9:0];
    assign is_digit  = (in_byte >= clpf_pkg::CHAR_ZERO) && (in_byte <= clpf_pkg::CHAR_NINE);
    assign digit_off = in_byte - clpf_pkg::CHAR_ZERO;
    assign length_acc = ({4'b0, length_value_reg} << 3) + ({4'b0, length_value_reg} << 1)
                      + {10'b0, digit_off[3:0]};

    always_comb
    begin
        case (header_position_reg[1:0])
            2'd0:    tag_char = clpf_pkg::TAG_S;
            2'd1:    tag_char = clpf_pkg::TAG_O;
            default: tag_char = clpf_pkg::TAG_W;
        endcase
    end

    always_comb
    begin
        header_position_next    = header_position_reg;
        tag_match_next          = tag_match_reg;
        data_command_next       = data_command_reg;
        comma_count_next        = comma_count_reg;
        length_digits_seen_next = length_digits_seen_reg;
        length_value_next       = length_value_reg;
        length_stopped_next     = length_stopped_reg;
        in_payload_next         = in_payload_reg;
        payload_count_next      = payload_count_reg;
        clear_state             = 1'b0;

        res.kind            = clpf_pkg::KIND_HEADER;
        res.data            = in_byte;
        res.index           = hp_index;
        res.is_data_command = data_command_reg;
        res.payload_length  = in_payload_reg ? length_value_reg : 10'd0;

        if (in_payload_reg)
        begin
            res.index = payload_count_reg;
            if (payload_count_reg < length_value_reg)
            begin
                res.kind           = clpf_pkg::KIND_PAYLOAD;
                payload_count_next = payload_count_reg + 10'd1;
            end
            else
            begin
                res.kind    = (in_byte == clpf_pkg::CHAR_NL) ? clpf_pkg::KIND_DONE
                                                              : clpf_pkg::KIND_ERROR;
                clear_state = 1'b1;
            end
        end
        else if (in_byte == clpf_pkg::CHAR_NL)
        begin
            res.kind    = clpf_pkg::KIND_DONE;
            clear_state = 1'b1;
        end
        else if (header_position_reg >= HDR_LIMIT)
        begin
            res.kind    = clpf_pkg::KIND_ERROR;
            clear_state = 1'b1;
        end
        else
        begin
            if (header_position_reg < TAG_LEN)
            begin
                if (in_byte != tag_char)
                begin
                    tag_match_next = 1'b0;
                end
                if (header_position_reg == TAG_LAST)
                begin
                    data_command_next = tag_match_next;
                end
            end
            if (data_command_next)
            begin
                if (in_byte == clpf_pkg::CHAR_COMMA)
                begin
                    comma_count_next = comma_count_reg + 2'd1;
                    if (comma_count_next == clpf_pkg::COMMAS_ALL)
                    begin
                        in_payload_next = 1'b1;
                    end
                end
                else if (comma_count_reg == clpf_pkg::COMMAS_LEN && !length_stopped_reg)
                begin
                    if (is_digit && length_digits_seen_reg < DIG_LIMIT)
                    begin
                        length_value_next = (length_acc > {4'b0, clpf_pkg::LEN_SAT})
                                          ? clpf_pkg::LEN_SAT : length_acc[9:0];
                        length_digits_seen_next = length_digits_seen_reg + DSW'(1);
                    end
                    else
                    begin
                        length_stopped_next = 1'b1;
                    end
                end
            end
            res.is_data_command  = data_command_next;
            res.payload_length   = in_payload_next ? length_value_next : 10'd0;
            header_position_next = header_position_reg + HPW'(1);
        end

        if (clear_state)
        begin
            header_position_next    = '0;
            tag_match_next          = 1'b1;
            data_command_next       = 1'b0;
            comma_count_next        = '0;
            length_digits_seen_next = '0;
            length_value_next       = '0;
            length_stopped_next     = 1'b0;
            in_payload_next         = 1'b0;
            payload_count_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_position_reg    <= '0;
            tag_match_reg          <= 1'b1;
            data_command_reg       <= 1'b0;
            comma_count_reg        <= '0;
            length_digits_seen_reg <= '0;
            length_value_reg       <= '0;
            length_stopped_reg     <= 1'b0;
            in_payload_reg         <= 1'b0;
            payload_count_reg      <= '0;
        end
        else if (step)
        begin
            header_position_reg    <= header_position_next;
            tag_match_reg          <= tag_match_next;
            data_command_reg       <= data_command_next;
            comma_count_reg        <= comma_count_next;
            length_digits_seen_reg <= length_digits_seen_next;
            length_value_reg       <= length_value_next;
            length_stopped_reg     <= length_stopped_next;
            in_payload_reg         <= in_payload_next;
            payload_count_reg      <= payload_count_next;
        end
    end

endmodule

/* hw/rtl/command_line_length_payload_framer.sv */
// top level of the command line length payload framer
// depends on clpf_pkg and clpf_core
// an accepted beat goes to the input register, its result then to the result register
// throughput: one byte per cycle unless out_ready stalls; state updates in clpf_core
// reset: asynchronous active-low rst_n clears both registers' valid bits and framer state
module command_line_length_payload_framer #(
    parameter int HEADER_MAX    = 256,
    parameter int LENGTH_DIGITS = 3
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] out_kind,
    output logic [7:0] out_byte,
    output logic [9:0] out_index,
    output logic       is_data_command,
    output logic [9:0] payload_length
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    clpf_pkg::result_t out_res_reg;
    clpf_pkg::result_t res;
    logic              advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    clpf_core #(
        .HEADER_MAX    (HEADER_MAX),
        .LENGTH_DIGITS (LENGTH_DIGITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .in_byte (in_byte_reg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_kind        = out_res_reg.kind;
    assign out_byte        = out_res_reg.data;
    assign out_index       = out_res_reg.index;
    assign is_data_command = out_res_reg.is_data_command;
    assign payload_length  = out_res_reg.payload_length;

    // empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    // payload beats only belong to a data command
    a_payload_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_res_reg.kind == clpf_pkg::KIND_PAYLOAD) |-> is_data_command)
        else $error("payload beat outside a data command");

    // payload beat index stays below the decoded length
    a_payload_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_res_reg.kind == clpf_pkg::KIND_PAYLOAD) |->
            (out_index < payload_length))
        else $error("payload index beyond decoded length");

endmodule

/* sim/tb_top.sv */
// testbench for command_line_length_payload_framer: random and directed serial bytes,
// own framing predictor, in-order field compare of every result beat
// depends on clpf_pkg and the framer rtl
module tb_top;

    localparam int HDR_MAX    = 256;
    localparam int LEN_DIGITS = 3;
    localparam int PHASE_BEATS = 85;
    localparam int HOLD_CYCLES = 300;
    localparam int SEND_GAP [4] = '{0, 46, 0, 8};
    localparam int RECV_STALL [4] = '{0, 0, 46, 8};

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [9:0] out_index;
    logic       is_data_command;
    logic [9:0] payload_length;

    logic [7:0]        byte_q [$];
    clpf_pkg::result_t frame_q [$];
    int         gap_pct = 0;
    int         stall_pct = 0;
    int         err_cnt = 0;
    logic       hold_go = 1'b0;
    logic       holding = 1'b0;

    // framer state
    logic [8:0] hdr_pos;
    logic       tag_ok;
    logic       sow_cmd;
    logic [1:0] commas;
    logic [1:0] len_digits;
    logic [9:0] len_val;
    logic       len_stop;
    logic       pay_on;
    logic [9:0] pay_cnt;

    command_line_length_payload_framer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_byte         (in_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_kind        (out_kind),
        .out_byte        (out_byte),
        .out_index       (out_index),
        .is_data_command (is_data_command),
        .payload_length  (payload_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void clear_line();
        hdr_pos    = '0;
        tag_ok     = 1'b1;
        sow_cmd    = 1'b0;
        commas     = '0;
        len_digits = '0;
        len_val    = '0;
        len_stop   = 1'b0;
        pay_on     = 1'b0;
        pay_cnt    = '0;
    endfunction

    function automatic clpf_pkg::result_t frame_byte(input logic [7:0] c);
        clpf_pkg::result_t r;
        logic [7:0]        tag_char;
        int                nv;
        r.data = c;
        r.is_data_command = sow_cmd;
        if (pay_on)
        begin
            r.index = pay_cnt;
            r.payload_length = len_val;
            if (pay_cnt < len_val)
            begin
                r.kind = clpf_pkg::KIND_PAYLOAD;
                pay_cnt++;
            end
            else
            begin
                r.kind = (c == clpf_pkg::CHAR_NL) ? clpf_pkg::KIND_DONE
                                                  : clpf_pkg::KIND_ERROR;
                clear_line();
            end
            return r;
        end
        if (c == clpf_pkg::CHAR_NL || hdr_pos >= HDR_MAX)
        begin
            r.kind = (c == clpf_pkg::CHAR_NL) ? clpf_pkg::KIND_DONE
                                              : clpf_pkg::KIND_ERROR;
            r.index = 10'(hdr_pos);
            r.payload_length = '0;
            clear_line();
            return r;
        end
        if (hdr_pos < 3)
        begin
            tag_char = (hdr_pos == 0) ? clpf_pkg::TAG_S
                     : (hdr_pos == 1) ? clpf_pkg::TAG_O : clpf_pkg::TAG_W;
            if (c != tag_char)
                tag_ok = 1'b0;
            if (hdr_pos == 2)
                sow_cmd = tag_ok;
        end
        if (sow_cmd)
        begin
            if (c == clpf_pkg::CHAR_COMMA)
            begin
                commas++;
                if (commas == clpf_pkg::COMMAS_ALL)
                    pay_on = 1'b1;
            end
            else if (commas == clpf_pkg::COMMAS_LEN && !len_stop)
            begin
                if (c >= clpf_pkg::CHAR_ZERO && c <= clpf_pkg::CHAR_NINE
                    && len_digits < LEN_DIGITS)
                begin
                    nv = int'(len_val) * 10 + int'(c - clpf_pkg::CHAR_ZERO);
                    len_val = (nv > int'(clpf_pkg::LEN_SAT)) ? clpf_pkg::LEN_SAT : 10'(nv);
                    len_digits++;
                end
                else
                    len_stop = 1'b1;
            end
        end
        r.kind = clpf_pkg::KIND_HEADER;
        r.index = 10'(hdr_pos);
        r.is_data_command = sow_cmd;
        r.payload_length = pay_on ? len_val : '0;
        hdr_pos++;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    function automatic logic [7:0] plain_byte(input bit allow_comma);
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == clpf_pkg::CHAR_NL || (!allow_comma && b == clpf_pkg::CHAR_COMMA));
        return b;
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            byte_q.push_back(s[i]);
    endtask

    task automatic push_packet(input string field, input int len, input bit bad_end);
        push_text("SOW");
        repeat ($urandom_range(3)) byte_q.push_back(plain_byte(1'b0));
        byte_q.push_back(clpf_pkg::CHAR_COMMA);
        repeat ($urandom_range(3)) byte_q.push_back(plain_byte(1'b0));
        byte_q.push_back(clpf_pkg::CHAR_COMMA);
        push_text(field);
        byte_q.push_back(clpf_pkg::CHAR_COMMA);
        repeat (len) byte_q.push_back(8'($urandom_range(255)));
        byte_q.push_back(bad_end ? plain_byte(1'b1) : clpf_pkg::CHAR_NL);
    endtask

    task automatic push_random_line();
        string field;
        int    sel;
        int    val;
        int    len;
        int    cnt;
        sel = $urandom_range(99);
        if (sel < 55)
        begin
            val = ($urandom_range(9) == 0) ? $urandom_range(120) : $urandom_range(24);
            case ($urandom_range(9))
                0: field = "";
                1: field = $sformatf(" %0d", val);
                2: field = $sformatf("%s%0d", ($urandom_range(1) != 0) ? "+" : "-", val);
                3: field = $sformatf("00%0d", val);
                4: field = $sformatf("%0dx%0d", val, $urandom_range(9));
                default: field = $sformatf("%0d", val);
            endcase
            // leading digits only, at most three
            len = 0;
            cnt = 0;
            for (int i = 0; i < field.len() && cnt < LEN_DIGITS; i++)
            begin
                if (field[i] < "0" || field[i] > "9")
                    break;
                len = len * 10 + (field[i] - "0");
                cnt++;
            end
            push_packet(field, len, $urandom_range(9) == 0);
        end
        else if (sel < 70)
        begin
            repeat ($urandom_range(20)) byte_q.push_back(plain_byte(1'b1));
            byte_q.push_back(clpf_pkg::CHAR_NL);
        end
        else if (sel < 80)
        begin
            // data command cut short before the payload
            push_text("SOW");
            repeat ($urandom_range(2))
            begin
                byte_q.push_back(clpf_pkg::CHAR_COMMA);
                repeat ($urandom_range(3)) byte_q.push_back(plain_byte(1'b0));
            end
            byte_q.push_back(clpf_pkg::CHAR_NL);
        end
        else if (sel < 88)
        begin
            // near miss on the tag
            case ($urandom_range(4))
                0: push_text("SOX");
                1: push_text("sOW");
                2: push_text("SQW");
                3: push_text("SO");
                default: push_text("S");
            endcase
            push_text(",,3,abc");
            byte_q.push_back(clpf_pkg::CHAR_NL);
        end
        else if (sel < 97)
        begin
            repeat ($urandom_range(12, 1)) byte_q.push_back(8'($urandom_range(255)));
        end
        else
            push_packet("0", 0, 1'b0);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                frame_q.push_back(frame_byte(in_byte));
            if (!in_valid || in_ready)
            begin
                if (byte_q.size() != 0 && $urandom_range(99) >= gap_pct)
                begin
                    in_byte  <= byte_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin : mon_blk
        clpf_pkg::result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (frame_q.size() == 0)
                begin
                    $error("unexpected beat: kind %0d byte %0h index %0d",
                           out_kind, out_byte, out_index);
                    err_cnt++;
                end
                else
                begin
                    want = frame_q.pop_front();
                    check_field("out_kind", 32'(want.kind), 32'(out_kind));
                    check_field("out_byte", 32'(want.data), 32'(out_byte));
                    check_field("out_index", 32'(want.index), 32'(out_index));
                    check_field("is_data_command", 32'(want.is_data_command),
                                32'(is_data_command));
                    check_field("payload_length", 32'(want.payload_length),
                                32'(payload_length));
                end
            end
            out_ready <= !holding && ($urandom_range(99) >= stall_pct);
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding <= 1'b0;
    end

    initial
    begin
        #3000000;
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        int target;
        clear_line();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 4; ph++)
        begin
            @(negedge clk);
            gap_pct = SEND_GAP[ph];
            stall_pct = RECV_STALL[ph];
            if (ph == 0)
            begin
                // byte extremes, payload holding newline and comma, zero length,
                // newline before the third comma
                byte_q.push_back(8'h00);
                byte_q.push_back(8'hFF);
                byte_q.push_back(clpf_pkg::CHAR_NL);
                push_text("SOW,,3,a");
                byte_q.push_back(clpf_pkg::CHAR_NL);
                byte_q.push_back(clpf_pkg::CHAR_COMMA);
                byte_q.push_back(clpf_pkg::CHAR_NL);
                push_text("SOW,,0,");
                byte_q.push_back(clpf_pkg::CHAR_NL);
                push_text("SOW,");
                byte_q.push_back(clpf_pkg::CHAR_NL);
                hold_go = 1'b1;
            end
            target = byte_q.size() + PHASE_BEATS;
            while (byte_q.size() < target)
                push_random_line();
            if (ph == 3)
            begin
                // length digits beyond the third, header overflow
                push_packet("1234", 123, 1'b0);
                repeat (HDR_MAX + 1) byte_q.push_back(plain_byte(1'b1));
                byte_q.push_back(clpf_pkg::CHAR_NL);
            end
            while (byte_q.size() != 0 || in_valid || frame_q.size() != 0)
                @(negedge clk);
        end
        repeat (10) @(posedge clk);
        if (err_cnt == 0 && frame_q.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/clpf_pkg.sv
hw/rtl/clpf_core.sv
hw/rtl/command_line_length_payload_framer.sv
sim/tb_top.sv
